FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the IQ imbalance compensator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/iqlms_pkg.sv
// Package of the IQ imbalance compensator: widths, formats, state codes and
// the controller command struct. Depends on nothing.
package iqlms_pkg;

  // Sample and weight formats.
  localparam int SAMPLE_WIDTH = 16;
  localparam int WEIGHT_WIDTH = 32;
  localparam int WEIGHT_FRAC  = 30;
  localparam int MU_WIDTH     = 16;
  localparam int MU_FRAC      = 20;
  localparam int UPD_SHIFT    = 2 * SAMPLE_WIDTH - 12;

  // Product widths: sample times weight, and mu times sample.
  localparam int CORR_PROD_W = SAMPLE_WIDTH + WEIGHT_WIDTH;
  localparam int MU_SAMP_W   = MU_WIDTH + 1 + SAMPLE_WIDTH;
  localparam int UPD_PROD_W  = SAMPLE_WIDTH + MU_SAMP_W;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_OUT  = 5'b00100,
    ST_PROD = 5'b01000,
    ST_UPD  = 5'b10000
  } iqlms_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_out;
    logic do_prod;
    logic do_upd;
  } iqlms_cmd_t;

endpackage

FILE: rtl/iqlms_if.sv
// Valid/ready stream interfaces for sample items and result items.
// Depends on iqlms_pkg for the sample width.
interface iqlms_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] i_in;
  logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] q_in;

  modport source (output valid, output i_in, output q_in, input ready);
  modport sink   (input valid, input i_in, input q_in, output ready);
endinterface

interface iqlms_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] i_out;
  logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] q_out;

  modport source (output valid, output i_out, output q_out, input ready);
  modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

FILE: rtl/iqlms_ctrl.sv
// Controller of the IQ imbalance compensator: sequences one item through
// the datapath and owns the result valid flag. Depends on iqlms_pkg.
module iqlms_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output iqlms_pkg::iqlms_cmd_t cmd
);

  iqlms_pkg::iqlms_state_t state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // A new item is taken when idle or in the weight update of the last one.
  assign in_ready  = (state_r == iqlms_pkg::ST_IDLE) || (state_r == iqlms_pkg::ST_UPD);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      iqlms_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = iqlms_pkg::ST_MUL;
        end
      end
      iqlms_pkg::ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = iqlms_pkg::ST_OUT;
      end
      iqlms_pkg::ST_OUT: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.do_out = 1'b1;
          state_nxt  = iqlms_pkg::ST_PROD;
        end
      end
      iqlms_pkg::ST_PROD: begin
        cmd.do_prod = 1'b1;
        state_nxt   = iqlms_pkg::ST_UPD;
      end
      iqlms_pkg::ST_UPD: begin
        cmd.do_upd = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = iqlms_pkg::ST_MUL;
        end else begin
          state_nxt = iqlms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iqlms_pkg::ST_IDLE;
      end
    endcase
  end

  // Result valid: set when the result register is written, cleared when the item is taken.
  always_comb begin
    if (cmd.do_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iqlms_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/iqlms_dp.sv
// Datapath of the IQ imbalance compensator: correction, saturation, LMS
// weight update and the step size register. Depends on iqlms_pkg.
module iqlms_dp (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  iqlms_pkg::iqlms_cmd_t                     cmd,
  input  logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] i_in,
  input  logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] q_in,
  input  logic                                      cfg_we,
  input  logic        [iqlms_pkg::MU_WIDTH-1:0]     cfg_wdata,
  output logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] i_out,
  output logic signed [iqlms_pkg::SAMPLE_WIDTH-1:0] q_out
);

  localparam int SW  = iqlms_pkg::SAMPLE_WIDTH;
  localparam int WW  = iqlms_pkg::WEIGHT_WIDTH;
  localparam int PAW = iqlms_pkg::CORR_PROD_W;
  localparam int MSW = iqlms_pkg::MU_SAMP_W;
  localparam int P2W = iqlms_pkg::UPD_PROD_W;
  localparam int DW  = PAW + 2;
  localparam int SUW = P2W + 1;

  localparam logic [PAW:0] HALF_CORR = (PAW+1)'(1) << (iqlms_pkg::WEIGHT_FRAC - 1);
  localparam logic [P2W:0] HALF_UPD  = (P2W+1)'(1) << (iqlms_pkg::UPD_SHIFT - 1);
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};

  logic        [iqlms_pkg::MU_WIDTH-1:0] mu_r;
  logic signed [SW-1:0]  si_r, sq_r;
  logic signed [WW-1:0]  w_qi_r, w_qi_nxt;
  logic signed [WW-1:0]  w_iq_r, w_iq_nxt;
  logic signed [PAW-1:0] pa_r, pb_r;
  logic signed [MSW-1:0] musi_r, musq_r;
  logic signed [SW-1:0]  io_r, qo_r, io_nxt, qo_nxt;
  logic signed [P2W-1:0] p2i_r, p2q_r;

  logic signed [PAW:0]   ra, rb;
  logic signed [DW-1:0]  da, db;
  logic signed [P2W:0]   ri, rq;
  logic signed [SUW-1:0] sui, suq;

  assign i_out = io_r;
  assign q_out = qo_r;

  // Step size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= '0;
    end else if (cfg_we) begin
      mu_r <= cfg_wdata;
    end
  end

  // Input capture and first multiplier stage.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      si_r <= i_in;
      sq_r <= q_in;
    end
    if (cmd.do_mul) begin
      pa_r   <= sq_r * w_qi_r;
      pb_r   <= si_r * w_iq_r;
      musi_r <= $signed({1'b0, mu_r}) * si_r;
      musq_r <= $signed({1'b0, mu_r}) * sq_r;
    end
  end

  // Round the correction half up, subtract it and saturate the outputs.
  always_comb begin
    ra = ($signed({pa_r[PAW-1], pa_r}) + $signed(HALF_CORR)) >>> iqlms_pkg::WEIGHT_FRAC;
    rb = ($signed({pb_r[PAW-1], pb_r}) + $signed(HALF_CORR)) >>> iqlms_pkg::WEIGHT_FRAC;
    da = DW'(si_r) - DW'(ra);
    db = DW'(sq_r) - DW'(rb);
    if ((&da[DW-1:SW-1]) || !(|da[DW-1:SW-1])) begin
      io_nxt = da[SW-1:0];
    end else begin
      io_nxt = da[DW-1] ? S_MIN : S_MAX;
    end
    if ((&db[DW-1:SW-1]) || !(|db[DW-1:SW-1])) begin
      qo_nxt = db[SW-1:0];
    end else begin
      qo_nxt = db[DW-1] ? S_MIN : S_MAX;
    end
  end

  // Result register; it also feeds the update products.
  always_ff @(posedge clk) begin
    if (cmd.do_out) begin
      io_r <= io_nxt;
      qo_r <= qo_nxt;
    end
    if (cmd.do_prod) begin
      p2i_r <= qo_r * musi_r;
      p2q_r <= io_r * musq_r;
    end
  end

  // Round the increments half up, accumulate and saturate the weights.
  always_comb begin
    ri  = ($signed({p2i_r[P2W-1], p2i_r}) + $signed(HALF_UPD)) >>> iqlms_pkg::UPD_SHIFT;
    rq  = ($signed({p2q_r[P2W-1], p2q_r}) + $signed(HALF_UPD)) >>> iqlms_pkg::UPD_SHIFT;
    sui = SUW'(w_iq_r) + SUW'(ri);
    suq = SUW'(w_qi_r) + SUW'(rq);
    if ((&sui[SUW-1:WW-1]) || !(|sui[SUW-1:WW-1])) begin
      w_iq_nxt = sui[WW-1:0];
    end else begin
      w_iq_nxt = sui[SUW-1] ? W_MIN : W_MAX;
    end
    if ((&suq[SUW-1:WW-1]) || !(|suq[SUW-1:WW-1])) begin
      w_qi_nxt = suq[WW-1:0];
    end else begin
      w_qi_nxt = suq[SUW-1] ? W_MIN : W_MAX;
    end
  end

  // Adaptive weights.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_qi_r <= '0;
      w_iq_r <= '0;
    end else if (cmd.do_upd) begin
      w_qi_r <= w_qi_nxt;
      w_iq_r <= w_iq_nxt;
    end
  end

endmodule

FILE: rtl/iq_imbalance_lms_compensator.sv
// Top level of the LMS IQ imbalance compensator: controller plus datapath.
// Depends on iqlms_pkg, iqlms_if, iqlms_ctrl, iqlms_dp and assert_macros.svh.
//
//   Channel   Direction  Handshake      Payload
//   in_ch     in         valid/ready    i_in, q_in (signed 16 bits)
//   out_ch    out        valid/ready    i_out, q_out (signed 16 bits)
//   cfg       in         cfg_we         cfg_wdata = step_size (16 bits)
//
// One item passes four steps: multiply, correct and saturate, update
// multiply, weight update; the next item is taken in the update step, so a
// new item is not accepted until the last one reaches its weight update.
// The result is held in an output register after the correct step; a
// stalled sink halts the controller only in the correct step.
// Reset (rst_n low, synchronous) clears the weights, step size and control.
`include "assert_macros.svh"

module iq_imbalance_lms_compensator (
  input  logic                               clk,
  input  logic                               rst_n,
  iqlms_in_if.sink                           in_ch,
  iqlms_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [iqlms_pkg::MU_WIDTH-1:0]     cfg_wdata
);

  iqlms_pkg::iqlms_cmd_t cmd;

  // Sequencer.
  iqlms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  iqlms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .i_in      (in_ch.i_in),
    .q_in      (in_ch.q_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .i_out     (out_ch.i_out),
    .q_out     (out_ch.q_out)
  );

  // One item at a time: no new item is taken in the multiply and correct steps after acceptance.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_NEXT(a_busy_two_cycles, clk, rst_n, in_ch.valid && in_ch.ready, ##1 !in_ch.ready)
  // A waiting result is never dropped.
  `ASSERT_NEXT(a_result_held, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)

endmodule
